[rtl/wsp_pkg.sv]
`timescale 1ns / 1ps
// types and constants shared by the websocket frame parser
// no dependencies

package wsp_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	localparam logic ERR_SHORT  = 1'b0;
	localparam logic ERR_LENGTH = 1'b1;

	typedef struct packed {
		kind_t       kind;
		logic        fin_flag;
		logic [2:0]  reserved_bits;
		logic [3:0]  frame_opcode;
		logic        masked_flag;
		logic [31:0] payload_len;
		logic [7:0]  data_byte;
		logic        frame_end;
		logic        error_code;
	} res_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       buffer_end;
	} in_item_t;

endpackage

[rtl/websocket_frame_parser_top.sv]
`timescale 1ns / 1ps
// websocket frame parser: one received byte per item, at most one result per item
// throughput one item per cycle; two register stages: an accepted item passes through
// the input register, then parser logic into the result register
// the result register's readiness sets the rate when the output side stalls
// reset (async, active low) empties both registers and rearms the header parser
// depends on wsp_pkg, wsp_in_reg, wsp_core, wsp_out_reg

module websocket_frame_parser_top #(
	parameter int LENGTH_BITS = wsp_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        buffer_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic        fin_flag,
	output logic [2:0]  reserved_bits,
	output logic [3:0]  frame_opcode,
	output logic        masked_flag,
	output logic [31:0] payload_len,
	output logic [7:0]  data_byte,
	output logic        frame_end,
	output logic        error_code
);
	import wsp_pkg::*;

	in_item_t in_item, item_s1;
	logic     valid_s1, free, step, has_res;
	res_t     res, res_q;

	assign in_item.byte_value = byte_value;
	assign in_item.buffer_end = buffer_end;
	assign step = valid_s1 && free;

	wsp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wsp_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.has_res (has_res),
		.res     (res)
	);

	wsp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && has_res),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign kind           = res_q.kind;
	assign fin_flag       = res_q.fin_flag;
	assign reserved_bits  = res_q.reserved_bits;
	assign frame_opcode   = res_q.frame_opcode;
	assign masked_flag    = res_q.masked_flag;
	assign payload_len    = res_q.payload_len;
	assign data_byte      = res_q.data_byte;
	assign frame_end      = res_q.frame_end;
	assign error_code     = res_q.error_code;

	// error items carry nothing but their code
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> payload_len == 32'd0 && data_byte == 8'h00)
		else $error("error item with header fields set");

	// header marks frame end exactly for an empty frame
	a_hdr_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_HEADER |-> frame_end == (payload_len == 32'd0))
		else $error("header frame_end does not match length");

	// payload bytes only belong to frames with a nonzero length
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DATA |-> payload_len != 32'd0 && error_code == 1'b0)
		else $error("payload item of an empty frame");

endmodule

[rtl/wsp_in_reg.sv]
`timescale 1ns / 1ps
// input register of the websocket frame parser
// depends on wsp_pkg

module wsp_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wsp_pkg::in_item_t in_item,
	input  logic              take,
	output logic              valid_s1,
	output wsp_pkg::in_item_t item_s1
);
	import wsp_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

[rtl/wsp_core.sv]
`timescale 1ns / 1ps
// frame header parser state and per-byte result logic
// depends on wsp_pkg

module wsp_core #(
	parameter int LENGTH_BITS = wsp_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  wsp_pkg::in_item_t item,
	output logic              has_res,
	output wsp_pkg::res_t     res
);
	import wsp_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DONE    = 3'd5,
		PH_SKIP    = 3'd6
	} phase_t;

	// bits of the length that must be clear to fit in LENGTH_BITS
	localparam logic [63:0] LimOne  = 64'd1 << LENGTH_BITS;
	localparam logic [31:0] LimMask = 32'(~(LimOne - 64'd1));

	phase_t                  phase_q, n_phase;
	logic [7:0]              fhb_q, n_fhb;
	logic                    mask_q, n_mask;
	logic [3:0]              ecnt_q, n_ecnt;
	logic [31:0]             acc_q, n_acc;
	logic [31:0]             key_q, n_key;
	logic [1:0]              kidx_q, n_kidx;
	logic [LENGTH_BITS-1:0]  rem_q, n_rem;

	logic [31:0] key_sh;
	logic [7:0]  kb;
	logic [7:0]  b;
	logic        do_len, do_hdr, err_set, err_code;

	assign b      = item.byte_value;
	assign key_sh = key_q >> {~kidx_q, 3'b000};
	assign kb     = mask_q ? key_sh[7:0] : 8'h00;

	always_comb begin
		n_phase  = phase_q;
		n_fhb    = fhb_q;
		n_mask   = mask_q;
		n_ecnt   = ecnt_q;
		n_acc    = acc_q;
		n_key    = key_q;
		n_kidx   = kidx_q;
		n_rem    = rem_q;
		do_len   = 1'b0;
		do_hdr   = 1'b0;
		err_set  = 1'b0;
		err_code = ERR_SHORT;
		has_res  = 1'b0;
		res      = '0;

		case (phase_q)
			PH_FIRST: begin
				n_fhb   = b;
				n_phase = PH_SECOND;
			end
			PH_SECOND: begin
				n_mask = b[7];
				n_acc  = '0;
				if (b[6:0] <= 7'd125) begin
					n_acc  = {25'd0, b[6:0]};
					do_len = 1'b1;
				end else if (b[6:0] == 7'd126) begin
					n_ecnt  = 4'd2;
					n_phase = PH_EXTLEN;
				end else begin
					n_ecnt  = 4'd8;
					n_phase = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				// upper four bytes of a 64-bit length must be zero
				if (ecnt_q > 4'd4 && b != 8'h00) begin
					err_set  = 1'b1;
					err_code = ERR_LENGTH;
				end else begin
					if (ecnt_q <= 4'd4) begin
						n_acc = {acc_q[23:0], b};
					end
					n_ecnt = ecnt_q - 4'd1;
					if (n_ecnt == 4'd0) begin
						do_len = 1'b1;
					end
				end
			end
			PH_KEY: begin
				n_key = {key_q[23:0], b};
				if (kidx_q == 2'd3) begin
					do_hdr = 1'b1;
				end else begin
					n_kidx = kidx_q + 2'd1;
				end
			end
			PH_PAYLOAD: begin
				has_res              = 1'b1;
				res.kind             = KIND_DATA;
				res.fin_flag         = fhb_q[7];
				res.reserved_bits    = fhb_q[6:4];
				res.frame_opcode     = fhb_q[3:0];
				res.masked_flag      = mask_q;
				res.payload_len      = acc_q;
				res.data_byte        = b ^ kb;
				res.frame_end        = (rem_q == LENGTH_BITS'(1));
				n_rem                = rem_q - LENGTH_BITS'(1);
				n_kidx               = kidx_q + 2'd1;
				if (n_rem == '0) begin
					n_phase = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		if (do_len) begin
			if ((n_acc & LimMask) != 32'd0) begin
				err_set  = 1'b1;
				err_code = ERR_LENGTH;
			end else if (n_mask) begin
				n_kidx  = 2'd0;
				n_key   = '0;
				n_phase = PH_KEY;
			end else begin
				do_hdr = 1'b1;
			end
		end

		if (do_hdr) begin
			has_res            = 1'b1;
			res                = '0;
			res.kind           = KIND_HEADER;
			res.fin_flag       = n_fhb[7];
			res.reserved_bits  = n_fhb[6:4];
			res.frame_opcode   = n_fhb[3:0];
			res.masked_flag    = n_mask;
			res.payload_len    = n_acc;
			res.frame_end      = (n_acc == 32'd0);
			n_rem              = n_acc[LENGTH_BITS-1:0];
			n_kidx             = 2'd0;
			n_phase            = (n_acc == 32'd0) ? PH_DONE : PH_PAYLOAD;
		end

		if (err_set) begin
			has_res        = 1'b1;
			res            = '0;
			res.kind       = KIND_ERROR;
			res.error_code = err_code;
			n_phase        = PH_SKIP;
		end

		// buffer end: report an unfinished frame, then rearm
		if (item.buffer_end) begin
			if (n_phase != PH_DONE && n_phase != PH_SKIP) begin
				has_res        = 1'b1;
				res            = '0;
				res.kind       = KIND_ERROR;
				res.error_code = ERR_SHORT;
			end
			n_phase = PH_FIRST;
			n_fhb   = '0;
			n_mask  = 1'b0;
			n_ecnt  = '0;
			n_acc   = '0;
			n_key   = '0;
			n_kidx  = '0;
			n_rem   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			fhb_q   <= '0;
			mask_q  <= 1'b0;
			ecnt_q  <= '0;
			acc_q   <= '0;
			key_q   <= '0;
			kidx_q  <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= n_phase;
			fhb_q   <= n_fhb;
			mask_q  <= n_mask;
			ecnt_q  <= n_ecnt;
			acc_q   <= n_acc;
			key_q   <= n_key;
			kidx_q  <= n_kidx;
			rem_q   <= n_rem;
		end
	end

endmodule

[rtl/wsp_out_reg.sv]
`timescale 1ns / 1ps
// result register of the websocket frame parser
// depends on wsp_pkg

module wsp_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  wsp_pkg::res_t res,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output wsp_pkg::res_t res_q
);
	import wsp_pkg::*;

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule
